// ===== design/msort_pkg.sv =====
// ----------------------------------------------------------------------------
// msort_pkg
// shared types and constants for the merge sort engine
// ----------------------------------------------------------------------------
package msort_pkg;

  localparam int unsigned DATA_W = 32;

  typedef struct packed {
    logic [DATA_W-1:0] value;
    logic              last;
  } item_t;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_BLOCK,
    ST_READ,
    ST_MERGE,
    ST_EMIT_RD,
    ST_EMIT_LD,
    ST_EMIT_WAIT
  } state_t;

endpackage

// ===== design/msort_ram.sv =====
// ----------------------------------------------------------------------------
// msort_ram
// generic ram, one write port, two registered read ports
// ----------------------------------------------------------------------------
module msort_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_a,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

// ===== design/msort_queue.sv =====
// ----------------------------------------------------------------------------
// msort_queue
// front end: two-entry queue that takes input transfers
// ----------------------------------------------------------------------------
module msort_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  msort_pkg::item_t    in_item,
  output logic                out_valid,
  input  logic                out_ready,
  output msort_pkg::item_t    out_item
);

  msort_pkg::item_t slot_r [2];
  logic             wptr_r, wptr_nxt;
  logic             rptr_r, rptr_nxt;
  logic [1:0]       fill_r, fill_nxt;
  logic             push, pop;

  assign in_ready  = (fill_r != 2'd2);
  assign out_valid = (fill_r != 2'd0);
  assign out_item  = slot_r[rptr_r];
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;

  always_comb begin
    wptr_nxt = push ? ~wptr_r : wptr_r;
    rptr_nxt = pop ? ~rptr_r : rptr_r;
    fill_nxt = fill_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= 1'b0;
      rptr_r <= 1'b0;
      fill_r <= 2'd0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      fill_r <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wptr_r] <= in_item;
    end
  end

endmodule

// ===== design/msort_core.sv =====
// ----------------------------------------------------------------------------
// msort_core
// back end: stores the run, bottom-up stable merge passes, sorted output
// ----------------------------------------------------------------------------
module msort_core #(
  parameter int unsigned MAX_ELEMENTS = 64
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            item_valid,
  output logic                            item_ready,
  input  msort_pkg::item_t                item,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [msort_pkg::DATA_W-1:0]    out_tdata,
  output logic                            out_tlast
);

  localparam int unsigned AW = $clog2(MAX_ELEMENTS);
  localparam int unsigned CW = $clog2(MAX_ELEMENTS + 1);
  localparam int unsigned BW = CW + 2;
  localparam logic [CW-1:0] MAX_CNT = CW'(MAX_ELEMENTS);

  msort_pkg::state_t state_r, state_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [BW-1:0] lo_r, lo_nxt, w_r, w_nxt, o_r, o_nxt, p_r, p_nxt, q_r, q_nxt;
  logic          src_r, src_nxt;
  logic          ovalid_r, ovalid_nxt;
  logic [msort_pkg::DATA_W-1:0] odata_r, odata_nxt;
  logic          olast_r, olast_nxt;

  logic [BW-1:0] cnt_b, mid_raw, hi_raw, mid, hi, w2;
  logic          take_left;
  logic          we0, we1;
  logic [AW-1:0] waddr, raddr_a, raddr_b;
  logic [msort_pkg::DATA_W-1:0] wdata;
  logic [msort_pkg::DATA_W-1:0] rd0_a, rd0_b, rd1_a, rd1_b, da, db;
  logic [CW-1:0] count_inc;

  assign cnt_b   = BW'(count_r);
  assign mid_raw = lo_r + w_r;
  assign hi_raw  = lo_r + (w_r << 1);
  assign mid     = (mid_raw > cnt_b) ? cnt_b : mid_raw;
  assign hi      = (hi_raw > cnt_b) ? cnt_b : hi_raw;
  assign w2      = w_r << 1;
  assign da      = src_r ? rd1_a : rd0_a;
  assign db      = src_r ? rd1_b : rd0_b;
  assign take_left = (p_r < mid) &&
                     ((q_r >= hi) || ($signed(da) <= $signed(db)));
  assign count_inc = (count_r < MAX_CNT) ? count_r + 1'b1 : count_r;

  assign item_ready = (state_r == msort_pkg::ST_LOAD);
  assign out_tvalid = ovalid_r;
  assign out_tdata  = odata_r;
  assign out_tlast  = olast_r;

  msort_ram #(.WIDTH(msort_pkg::DATA_W), .DEPTH(MAX_ELEMENTS)) u_bank0 (
    .clk(clk), .we(we0), .waddr(waddr), .wdata(wdata),
    .raddr_a(raddr_a), .raddr_b(raddr_b), .rdata_a(rd0_a), .rdata_b(rd0_b)
  );

  msort_ram #(.WIDTH(msort_pkg::DATA_W), .DEPTH(MAX_ELEMENTS)) u_bank1 (
    .clk(clk), .we(we1), .waddr(waddr), .wdata(wdata),
    .raddr_a(raddr_a), .raddr_b(raddr_b), .rdata_a(rd1_a), .rdata_b(rd1_b)
  );

  always_comb begin
    state_nxt  = state_r;
    count_nxt  = count_r;
    lo_nxt     = lo_r;
    w_nxt      = w_r;
    o_nxt      = o_r;
    p_nxt      = p_r;
    q_nxt      = q_r;
    src_nxt    = src_r;
    ovalid_nxt = ovalid_r;
    odata_nxt  = odata_r;
    olast_nxt  = olast_r;
    we0        = 1'b0;
    we1        = 1'b0;
    waddr      = count_r[AW-1:0];
    wdata      = item.value;
    raddr_a    = p_r[AW-1:0];
    raddr_b    = q_r[AW-1:0];
    unique case (state_r)
      msort_pkg::ST_LOAD: begin
        if (item_valid) begin
          we0       = (count_r < MAX_CNT);
          count_nxt = count_inc;
          if (item.last) begin
            lo_nxt  = '0;
            w_nxt   = BW'(1);
            o_nxt   = '0;
            src_nxt = 1'b0;
            if (count_inc <= CW'(1)) begin
              state_nxt = msort_pkg::ST_EMIT_RD;
            end else begin
              state_nxt = msort_pkg::ST_BLOCK;
            end
          end
        end
      end
      msort_pkg::ST_BLOCK: begin
        if (lo_r >= cnt_b) begin
          src_nxt = ~src_r;
          w_nxt   = w2;
          lo_nxt  = '0;
          o_nxt   = '0;
          if (w2 >= cnt_b) begin
            state_nxt = msort_pkg::ST_EMIT_RD;
          end
        end else begin
          p_nxt     = lo_r;
          q_nxt     = mid;
          o_nxt     = lo_r;
          state_nxt = msort_pkg::ST_READ;
        end
      end
      msort_pkg::ST_READ: begin
        state_nxt = msort_pkg::ST_MERGE;
      end
      msort_pkg::ST_MERGE: begin
        waddr = o_r[AW-1:0];
        wdata = take_left ? da : db;
        we0   = src_r;
        we1   = ~src_r;
        o_nxt = o_r + 1'b1;
        if (take_left) begin
          p_nxt = p_r + 1'b1;
        end else begin
          q_nxt = q_r + 1'b1;
        end
        if (o_nxt >= hi) begin
          lo_nxt    = hi;
          state_nxt = msort_pkg::ST_BLOCK;
        end else begin
          state_nxt = msort_pkg::ST_READ;
        end
      end
      msort_pkg::ST_EMIT_RD: begin
        raddr_a   = o_r[AW-1:0];
        state_nxt = msort_pkg::ST_EMIT_LD;
      end
      msort_pkg::ST_EMIT_LD: begin
        ovalid_nxt = 1'b1;
        odata_nxt  = da;
        olast_nxt  = (o_r + 1'b1 == cnt_b);
        state_nxt  = msort_pkg::ST_EMIT_WAIT;
      end
      msort_pkg::ST_EMIT_WAIT: begin
        if (out_tready) begin
          ovalid_nxt = 1'b0;
          o_nxt      = o_r + 1'b1;
          if (olast_r) begin
            count_nxt = '0;
            state_nxt = msort_pkg::ST_LOAD;
          end else begin
            state_nxt = msort_pkg::ST_EMIT_RD;
          end
        end
      end
      default: state_nxt = msort_pkg::ST_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= msort_pkg::ST_LOAD;
      count_r  <= '0;
      ovalid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      count_r  <= count_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    lo_r    <= lo_nxt;
    w_r     <= w_nxt;
    o_r     <= o_nxt;
    p_r     <= p_nxt;
    q_r     <= q_nxt;
    src_r   <= src_nxt;
    odata_r <= odata_nxt;
    olast_r <= olast_nxt;
  end

`ifndef SYNTHESIS
  a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= MAX_CNT) else $error("element count beyond store");
  a_emit_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    ovalid_r |-> count_r != '0) else $error("output with empty run");
  a_last_to_load: assert property (@(posedge clk) disable iff (!rst_n)
    (ovalid_r && out_tready && olast_r) |=> state_r == msort_pkg::ST_LOAD)
    else $error("no return to load after last transfer");
  a_merge_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == msort_pkg::ST_MERGE |-> o_r < hi) else $error("merge past block");
`endif

endmodule

// ===== design/merge_sort_engine.sv =====
// ----------------------------------------------------------------------------
// merge_sort_engine
// stable ascending sort of a run of signed 32-bit values
// ----------------------------------------------------------------------------
//  channel | dir | tdata           | tlast
//  in_     | in  | [31:0] value_in | is_last_in
//  out_    | out | [31:0] value_out| is_last_out
//
//  loading takes one element per cycle through a two-entry queue
//  sort: ceil(log2 n) passes; each block is set up, then each element is read and merged
//  output: each element is read, loaded, then held until taken, from the final bank
//  input stalls once the queue is full while a run is sorted or sent; reset is synchronous, active low
// ----------------------------------------------------------------------------
module merge_sort_engine #(
  parameter int unsigned MAX_ELEMENTS = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // value_in
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // value_out
  output logic        out_tlast
);

  msort_pkg::item_t in_item, q_item;
  logic             q_valid, q_ready;

  assign in_item.value = in_tdata;
  assign in_item.last  = in_tlast;

  msort_queue u_queue (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_tvalid), .in_ready(in_tready), .in_item(in_item),
    .out_valid(q_valid), .out_ready(q_ready), .out_item(q_item)
  );

  msort_core #(.MAX_ELEMENTS(MAX_ELEMENTS)) u_core (
    .clk(clk), .rst_n(rst_n),
    .item_valid(q_valid), .item_ready(q_ready), .item(q_item),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata), .out_tlast(out_tlast)
  );

endmodule

// ===== tb/testbench.sv =====
// ----------------------------------------------------------------------------
// merge sort engine testbench
// feeds runs of signed values with random gaps and back-pressure, predicts the
// stable ascending order of each run and checks every sorted output transfer
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

class sort_scoreboard;
  logic [31:0] run_store[$];
  logic [31:0] sorted_q[$];
  logic        last_q[$];
  int          mismatches;
  int          runs_done;
  int          outputs_seen;

  function void note_input(logic [31:0] value, logic last);
    logic [31:0] run[$];
    logic [31:0] key;
    int j;
    if (run_store.size() < 64) run_store.push_back(value);
    if (!last) return;
    run = run_store;
    // stable insertion sort on signed values
    for (int i = 1; i < run.size(); i++) begin
      key = run[i];
      j = i - 1;
      while (j >= 0 && $signed(run[j]) > $signed(key)) begin
        run[j + 1] = run[j];
        j--;
      end
      run[j + 1] = key;
    end
    foreach (run[k]) begin
      sorted_q.push_back(run[k]);
      last_q.push_back(k == run.size() - 1);
    end
    run_store.delete();
    runs_done++;
  endfunction

  function void check_output(logic [31:0] value, logic last);
    logic [31:0] exp_value;
    logic        exp_last;
    outputs_seen++;
    if (sorted_q.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("unexpected output %0d last %0b", $signed(value), last);
      return;
    end
    exp_value = sorted_q.pop_front();
    exp_last  = last_q.pop_front();
    if (value !== exp_value || last !== exp_last) begin
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch: expected %0d last %0b, got %0d last %0b",
                 $signed(exp_value), exp_last, $signed(value), last);
    end
  endfunction

  function int pending();
    return sorted_q.size();
  endfunction
endclass

module testbench;
  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata = '0;
  logic        in_tlast = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;
  logic        out_tlast;

  sort_scoreboard sb = new();
  int  idle_pct = 31;
  int  items_sent;
  int  quiet_cycles;

  merge_sort_engine uut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tlast(in_tlast),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tlast(out_tlast)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // checks and watchdog
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) sb.note_input(in_tdata, in_tlast);
      if (out_tvalid && out_tready) sb.check_output(out_tdata, out_tlast);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles > 20000) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

  // receiver back-pressure
  always @(posedge clk) begin
    if (!rst_n) out_tready <= 1'b0;
    else out_tready <= ($urandom_range(99) >= idle_pct);
  end

  task automatic send_item(logic [31:0] value, logic last);
    while ($urandom_range(99) < idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= value;
    in_tlast  <= last;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    items_sent++;
  endtask

  function automatic logic [31:0] pick_value();
    case ($urandom_range(5))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return $urandom_range(7);
      3: return -$urandom_range(7);
      default: return $urandom;
    endcase
  endfunction

  task automatic send_run(int len);
    for (int i = 0; i < len; i++) send_item(pick_value(), i == len - 1);
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  initial begin
    int len;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    // single element, extremes, duplicates for stability
    send_item(32'h8000_0000, 1'b1);
    send_item(32'h7fff_ffff, 1'b0);
    send_item(32'h8000_0000, 1'b0);
    send_item(32'h0000_0000, 1'b0);
    send_item(32'hffff_ffff, 1'b0);
    send_item(32'h0000_0001, 1'b0);
    send_item(32'hffff_ffff, 1'b1);
    send_run(2);
    for (int i = 0; i < 8; i++) send_item(32'h0000_0005, i == 7);
    for (int i = 0; i < 6; i++) send_item(6 - i, i == 5);
    drain();
    // full store, then extra elements dropped, up to and including the last mark
    for (int i = 0; i < 66; i++) send_item($urandom, i == 65);
    drain();
    // no idling on either side for a while
    idle_pct = 0;
    send_run(64);
    send_run(3);
    idle_pct = 31;
    while (items_sent < 160) begin
      len = $urandom_range(12, 1);
      send_run(len);
      if ($urandom_range(4) == 0) drain();
    end
    drain();
    repeat (200) @(posedge clk);
    $display("%0d items in %0d runs, %0d sorted outputs checked",
             items_sent, sb.runs_done, sb.outputs_seen);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end
endmodule
